// File: src/dms_pkg.sv
package dms_pkg;

	localparam int TIME_BITS = 31;
	localparam int ID_BITS   = 16;

	typedef logic [TIME_BITS-1:0] tick_t;
	typedef logic [ID_BITS-1:0]   tid_t;

	localparam tick_t TICK_MAX = {TIME_BITS{1'b1}};

	localparam logic [1:0] OUTCOME_MISS  = 2'd0;
	localparam logic [1:0] OUTCOME_IDLE  = 2'd1;
	localparam logic [1:0] OUTCOME_NO_RT = 2'd2;
	localparam logic [1:0] OUTCOME_SCHED = 2'd3;

	typedef struct packed {
		tick_t      now_tick;
		logic       from_release_queue;
		tick_t      release_tick;
		tid_t       thread_id;
		logic       rt_thread;
		tick_t      relative_deadline;
		tick_t      absolute_deadline;
		tick_t      remaining_ticks;
		logic       last_entry;
	} sched_in_t;

	typedef struct packed {
		logic [1:0] outcome;
		tid_t       chosen_thread;
		tick_t      granted_ticks;
	} sched_out_t;

	// running minima of one round
	typedef struct packed {
		logic  runnable_seen;
		logic  miss_found;
		tid_t  miss_id;
		logic  best_found;
		tid_t  best_id;
		tick_t best_rel_deadline;
		tick_t best_abs_deadline;
		tick_t best_remaining;
		tick_t earliest_release;
	} round_state_t;

	localparam round_state_t ROUND_RESET = '{
		runnable_seen:     1'b0,
		miss_found:        1'b0,
		miss_id:           '0,
		best_found:        1'b0,
		best_id:           '0,
		best_rel_deadline: '0,
		best_abs_deadline: '0,
		best_remaining:    '0,
		earliest_release:  TICK_MAX
	};

	function automatic tick_t gap_after(input tick_t tick, input tick_t now);
		gap_after = (tick > now) ? tick - now : '0;
	endfunction

endpackage

// File: src/dms_decide.sv
module dms_decide (
	input  dms_pkg::round_state_t st,
	input  dms_pkg::tick_t        now,
	output dms_pkg::sched_out_t   res
);

	dms_pkg::tick_t dgap;
	dms_pkg::tick_t pgap;
	dms_pkg::tick_t grant;

	assign dgap = dms_pkg::gap_after(st.best_abs_deadline, now);
	assign pgap = dms_pkg::gap_after(st.earliest_release, now);

	always_comb begin
		grant = st.best_remaining;
		if (dgap < grant) begin
			grant = dgap;
		end
		if (pgap < grant) begin
			grant = pgap;
		end
	end

	always_comb begin
		if (st.miss_found) begin
			res.outcome       = dms_pkg::OUTCOME_MISS;
			res.chosen_thread = st.miss_id;
			res.granted_ticks = '0;
		end else if (!st.runnable_seen) begin
			res.outcome       = dms_pkg::OUTCOME_IDLE;
			res.chosen_thread = '0;
			res.granted_ticks = pgap;
		end else if (!st.best_found) begin
			res.outcome       = dms_pkg::OUTCOME_NO_RT;
			res.chosen_thread = '0;
			res.granted_ticks = '0;
		end else begin
			res.outcome       = dms_pkg::OUTCOME_SCHED;
			res.chosen_thread = st.best_id;
			res.granted_ticks = grant;
		end
	end

endmodule

// File: src/deadline_monotonic_scheduler.sv
// An accepted descriptor is registered in item_s1; when a last_entry item advances,
// the round's result is registered in out_q, and a held result stalls that item in item_s1.
// Throughput: one descriptor per cycle; a held result only stalls a last_entry item.
// Reset: arst_n clears the running minima (earliest release to all ones) and
// empties the input and result registers.
module deadline_monotonic_scheduler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dms_pkg::sched_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dms_pkg::sched_out_t  out_data
);

	logic                   valid_s1;
	dms_pkg::sched_in_t     item_s1;
	dms_pkg::round_state_t  state_q;
	dms_pkg::round_state_t  state_nx;
	dms_pkg::sched_out_t    res;
	dms_pkg::sched_out_t    out_q;
	logic                   out_valid_q;
	logic                   adv_s1;
	logic                   runnable;
	logic                   take_best;

	assign adv_s1   = valid_s1 && (!item_s1.last_entry || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign runnable = !(item_s1.from_release_queue &&
		item_s1.release_tick > item_s1.now_tick);

	assign take_best = item_s1.rt_thread && (!state_q.best_found ||
		item_s1.relative_deadline < state_q.best_rel_deadline ||
		(item_s1.relative_deadline == state_q.best_rel_deadline &&
		 item_s1.thread_id < state_q.best_id));

	always_comb begin
		state_nx = state_q;
		if (!runnable) begin
			if (item_s1.release_tick < state_q.earliest_release) begin
				state_nx.earliest_release = item_s1.release_tick;
			end
		end else begin
			state_nx.runnable_seen = 1'b1;
			if (item_s1.absolute_deadline <= item_s1.now_tick &&
			    (!state_q.miss_found || item_s1.thread_id < state_q.miss_id)) begin
				state_nx.miss_found = 1'b1;
				state_nx.miss_id    = item_s1.thread_id;
			end
			if (take_best) begin
				state_nx.best_found        = 1'b1;
				state_nx.best_id           = item_s1.thread_id;
				state_nx.best_rel_deadline = item_s1.relative_deadline;
				state_nx.best_abs_deadline = item_s1.absolute_deadline;
				state_nx.best_remaining    = item_s1.remaining_ticks;
			end
		end
	end

	dms_decide u_decide (
		.st  (state_nx),
		.now (item_s1.now_tick),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dms_pkg::ROUND_RESET;
		end else if (adv_s1) begin
			state_q <= item_s1.last_entry ? dms_pkg::ROUND_RESET : state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last_entry) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last_entry) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_round_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.last_entry |=>
		!state_q.runnable_seen && !state_q.miss_found && !state_q.best_found)
		else $error("round state not cleared after decision");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last_entry && out_valid_q && !out_ready |-> !in_ready)
		else $error("pending result would be overwritten");

	a_idle_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.outcome == dms_pkg::OUTCOME_IDLE ||
		out_q.outcome == dms_pkg::OUTCOME_NO_RT) |-> out_q.chosen_thread == '0)
		else $error("thread id set on idle or no real-time outcome");

	a_miss_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.outcome == dms_pkg::OUTCOME_MISS ||
		out_q.outcome == dms_pkg::OUTCOME_NO_RT) |-> out_q.granted_ticks == '0)
		else $error("time granted on miss or no real-time outcome");

endmodule
